>>> rtl/core/hs_pkg.sv
// shared constants and types of the heap sorter core
// no dependencies; used by hs_cmp and heap_sorter_core
`default_nettype none

package hs_pkg;

    // store depth default and word width
    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;

    // result of the shared compare-select unit, take_right has priority
    typedef struct packed {
        logic take_left;
        logic take_right;
    } hs_pick_t;

endpackage

`default_nettype wire

>>> rtl/core/heap_sorter_core.sv
// heap sorter top level: value store, sift-down sequencer and output register
// depends on hs_pkg, hs_ram, hs_cmp
//
//  channel   dir  tdata            tlast      tuser
//  s_        in   value_in[31:0]   last_in    -
//  m_        out  sorted_value     last_out   overflow
//
// loading takes one word per cycle; the last word starts the sort.
// sort: heap building fetches each node (BUILD) and latches it (LOAD); each extraction
// reads root and tail (EXTR) and swaps them (SWAP); the value then sinks one heap
// level per compare state (one pass of the shared compare unit per level).
// results then leave one at a time; the next loads only once the current is taken.
// s_tready is low from the last word until the last result is taken.
// synchronous active-low reset clears control state; the store is not cleared.
`default_nettype none

module heap_sorter_core
    import hs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value_in
    input  wire logic              s_tlast,   // last_in
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                   m_tlast,   // last_out
    output logic                   m_tuser    // [0] overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BUILD  = 4'd1;
    localparam logic [3:0] ST_LOAD   = 4'd2;
    localparam logic [3:0] ST_CMP    = 4'd3;
    localparam logic [3:0] ST_EXTR   = 4'd4;
    localparam logic [3:0] ST_SWAP   = 4'd5;
    localparam logic [3:0] ST_OUT_RD = 4'd6;
    localparam logic [3:0] ST_OUT_LD = 4'd7;
    localparam logic [3:0] ST_OUT_HD = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic              build_reg, build_next;
    logic [CW-1:0]     bidx_reg, bidx_next;
    logic [AW-1:0]     end_reg, end_next;
    logic [CW-1:0]     size_reg, size_next;
    logic [AW-1:0]     node_reg, node_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    logic [AW-1:0]     k_reg, k_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr_a, ram_raddr_b;
    logic [DATA_W-1:0] ram_rdata_a, ram_rdata_b;

    logic [AW-1:0]     rd_node;
    logic [IW-1:0]     rd_left, rd_right;
    logic [IW-1:0]     left_idx, right_idx;
    logic              left_ok, right_ok;
    hs_pick_t          pick;
    logic              s_acc, m_acc, store_room;
    logic [CW-1:0]     n_set;

    hs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // children of the node under sift; ram read data holds them in the compare state
    assign left_idx  = (IW'(node_reg) << 1) + IW'(1);
    assign right_idx = left_idx + IW'(1);
    assign left_ok   = left_idx < IW'(size_reg);
    assign right_ok  = right_idx < IW'(size_reg);

    hs_cmp u_cmp (
        .cur_val   ($signed(cur_reg)),
        .left_val  ($signed(ram_rdata_a)),
        .right_val ($signed(ram_rdata_b)),
        .left_ok   (left_ok),
        .right_ok  (right_ok),
        .pick      (pick)
    );

    // node whose children are fetched next
    always_comb begin
        rd_node = node_reg;
        if (state_reg == ST_SWAP) begin
            rd_node = '0;
        end else if (state_reg == ST_CMP) begin
            priority if (pick.take_right) begin
                rd_node = right_idx[AW-1:0];
            end else if (pick.take_left) begin
                rd_node = left_idx[AW-1:0];
            end else begin
                rd_node = node_reg;
            end
        end
    end

    // child addresses of the node whose children are fetched next
    assign rd_left  = (IW'(rd_node) << 1) + IW'(1);
    assign rd_right = rd_left + IW'(1);

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign m_acc      = m_tvalid_reg && m_tready;
    assign store_room = fill_reg < CW'(DEPTH);
    assign n_set      = fill_reg + (store_room ? CW'(1) : CW'(0));

    // sequencer
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        build_next    = build_reg;
        bidx_next     = bidx_reg;
        end_next      = end_reg;
        size_next     = size_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_user_next   = m_user_reg;
        ram_we        = 1'b0;
        ram_waddr     = fill_reg[AW-1:0];
        ram_wdata     = s_tdata;
        ram_raddr_a   = rd_left[AW-1:0];
        ram_raddr_b   = rd_right[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                // store the word while there is room, else flag the drop
                if (s_acc) begin
                    ram_we = store_room;
                    if (store_room) begin
                        fill_next = n_set;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        fill_next = n_set;
                        k_next    = '0;
                        if (n_set < CW'(2)) begin
                            state_next = ST_OUT_RD;
                        end else begin
                            build_next = 1'b1;
                            bidx_next  = n_set >> 1;
                            size_next  = n_set;
                            state_next = ST_BUILD;
                        end
                    end
                end
            end
            ST_BUILD: begin
                // fetch the next heap-building node
                node_next   = AW'(bidx_reg - CW'(1));
                ram_raddr_a = AW'(bidx_reg - CW'(1));
                state_next  = ST_LOAD;
            end
            ST_LOAD: begin
                // latch the sinking value, fetch its children
                cur_next   = ram_rdata_a;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // one level of sift-down
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                priority if (pick.take_right) begin
                    ram_wdata = ram_rdata_b;
                    node_next = right_idx[AW-1:0];
                end else if (pick.take_left) begin
                    ram_wdata = ram_rdata_a;
                    node_next = left_idx[AW-1:0];
                end else begin
                    ram_wdata = cur_reg;
                    if (build_reg && (bidx_reg > CW'(1))) begin
                        bidx_next  = bidx_reg - CW'(1);
                        state_next = ST_BUILD;
                    end else if (build_reg) begin
                        build_next = 1'b0;
                        end_next   = AW'(fill_reg - CW'(1));
                        state_next = ST_EXTR;
                    end else if (end_reg > AW'(1)) begin
                        end_next   = end_reg - AW'(1);
                        state_next = ST_EXTR;
                    end else begin
                        k_next     = '0;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_EXTR: begin
                // fetch root and the tail word
                ram_raddr_a = '0;
                ram_raddr_b = end_reg;
                state_next  = ST_SWAP;
            end
            ST_SWAP: begin
                // root goes to the tail, old tail sinks from the root
                ram_we     = 1'b1;
                ram_waddr  = end_reg;
                ram_wdata  = ram_rdata_a;
                cur_next   = ram_rdata_b;
                node_next  = '0;
                size_next  = CW'(end_reg);
                state_next = ST_CMP;
            end
            ST_OUT_RD: begin
                ram_raddr_a = k_reg;
                state_next  = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                // load the output register
                m_tvalid_next = 1'b1;
                m_data_next   = ram_rdata_a;
                m_last_next   = (CW'(k_reg) + CW'(1)) == fill_reg;
                m_user_next   = ovf_reg;
                state_next    = ST_OUT_HD;
            end
            ST_OUT_HD: begin
                // wait for the word to be taken, prefetch the next one
                ram_raddr_a = k_reg + AW'(1);
                if (m_acc) begin
                    m_tvalid_next = 1'b0;
                    if (m_last_reg) begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_OUT_LD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            build_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            build_reg    <= build_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        bidx_reg   <= bidx_next;
        end_reg    <= end_next;
        size_reg   <= size_next;
        node_reg   <= node_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // input and output sides never open together
    a_busy_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // the sift node stays inside the heap
    a_node_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (CW'(node_reg) < size_reg))
        else $error("sift node outside heap");

    // taking the last result returns the block to loading with a clean count
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (fill_reg == '0) && !ovf_reg))
        else $error("run end did not clear the set");

endmodule

`default_nettype wire

>>> rtl/core/hs_ram.sv
// generic single-write, dual-read ram with registered read data
// no dependencies
`default_nettype none

module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

>>> rtl/core/hs_cmp.sv
// shared compare-select unit: picks the largest of parent and up to two children
// depends on hs_pkg
`default_nettype none

module hs_cmp
    import hs_pkg::*;
(
    input  wire logic signed [DATA_W-1:0] cur_val,
    input  wire logic signed [DATA_W-1:0] left_val,
    input  wire logic signed [DATA_W-1:0] right_val,
    input  wire logic                     left_ok,
    input  wire logic                     right_ok,
    output hs_pick_t                      pick
);

    logic signed [DATA_W-1:0] big_val;

    // left wins only when strictly greater, right only when strictly greater than the winner
    always_comb begin
        pick.take_left  = left_ok && (left_val > cur_val);
        big_val         = pick.take_left ? left_val : cur_val;
        pick.take_right = right_ok && (right_val > big_val);
    end

endmodule

`default_nettype wire
